>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Needs nothing else; each macro takes a label, clock, active-low reset and expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BISA_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define BISA_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/bisa_pkg.sv
// Shared constants and codes for the bitmap inode and sector allocator.
// No dependencies; used by the core and its checker.
package bisa_pkg;

  localparam int unsigned SECTOR_BYTES    = 512;
  localparam int unsigned MAX_MAP_SECTORS = 8;
  localparam int unsigned STORE_BYTES     = MAX_MAP_SECTORS * SECTOR_BYTES;

  localparam int unsigned ADDR_W   = 12;
  localparam int unsigned CNT_W    = $clog2(STORE_BYTES + 1);
  localparam int unsigned BIT_W    = ADDR_W + 3;
  localparam int unsigned SECS_W   = 4;
  localparam int unsigned RUN_W    = 16;
  localparam int unsigned IDX_W    = 17;
  localparam int unsigned FDS_W    = 16;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [7:0] BYTE_FULL = 8'hff;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_INODE  = 2'd1,
    FUNC_SECTOR = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_CONFLICT = 2'd2
  } stat_e;

  typedef enum logic [1:0] {
    REG_INODE_SECS  = 2'd0,
    REG_SECTOR_SECS = 2'd1,
    REG_FIRST_DATA  = 2'd2
  } reg_e;

endpackage

>>> rtl/bitmap_inode_sector_allocator_core.sv
// Bitmap inode and sector allocator core: two byte-wide bitmaps in on-chip memory.
// Depends on bisa_pkg for constants and codes.
//
//  channel   direction  signals                                   purpose
//  s_axis    in         tvalid tready tdata tuser                 load / allocate requests
//  m_axis    out        tvalid tready tdata tuser                 one result per request
//  cfg       in         cfg_valid_i cfg_ready_o cfg_index_i/data  register writes
//
// A load writes its byte straight into the selected bitmap. An allocation scans one
// bitmap byte per cycle through the single read port of the selected map, up to the
// first byte that is not full. A sector allocation adds two passes over the bytes of
// the run (check, then read-modify-write).
// Reset clears the control state and the registers; the bitmaps are not cleared.
// A result that is not taken blocks new requests until it leaves.
module bitmap_inode_sector_allocator_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // byte_address[11:0], byte_value[19:12], run_length[35:20], zero[39:36]
  input  logic [bisa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // func[1:0], map_select[2]
  input  logic [bisa_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // allocated_index[16:0], zero[23:17]
  output logic [bisa_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // status[1:0]
  output logic [bisa_pkg::OUT_USER_W-1:0]    m_axis_tuser,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bisa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bisa_pkg::FDS_W-1:0]         cfg_data_i
);
  import bisa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_FILL
  } state_e;

  state_e state_q;

  logic [SECS_W-1:0] ino_secs_q, sec_secs_q;
  logic [FDS_W-1:0]  first_data_q;

  logic              sel_q;
  logic [CNT_W-1:0]  nbytes_q;
  logic [CNT_W-1:0]  ia_q;
  logic              pv_q;
  logic [ADDR_W-1:0] pa_q;
  logic [BIT_W-1:0]  b_q, e_q;
  logic [RUN_W-1:0]  run_q;

  logic              m_valid_q;
  logic [IDX_W-1:0]  m_idx_q;
  logic [STAT_W-1:0] m_stat_q;

  logic [7:0] ino_mem_q [STORE_BYTES];
  logic [7:0] sec_mem_q [STORE_BYTES];
  logic [7:0] ino_rdata_q, sec_rdata_q;

  // Input field views.
  logic [1:0]        in_func;
  logic              in_sel;
  logic [ADDR_W-1:0] in_addr;
  logic [7:0]        in_val;
  logic [RUN_W-1:0]  in_run;

  assign in_func = s_axis_tuser[1:0];
  assign in_sel  = s_axis_tuser[2];
  assign in_addr = s_axis_tdata[ADDR_W-1:0];
  assign in_val  = s_axis_tdata[ADDR_W+7:ADDR_W];
  assign in_run  = s_axis_tdata[ADDR_W+8+RUN_W-1:ADDR_W+8];

  logic in_fire;
  assign s_axis_tready = (state_q == S_IDLE) && (!m_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - IDX_W){1'b0}}, m_idx_q};
  assign m_axis_tuser  = m_stat_q;

  // Bytes in use for the map an accepted allocation selects.
  logic [SECS_W-1:0] req_secs, req_secs_clamped;
  logic [CNT_W-1:0]  req_nbytes;
  always_comb begin
    req_secs = (in_func == FUNC_INODE) ? ino_secs_q : sec_secs_q;
    req_secs_clamped = (req_secs > SECS_W'(MAX_MAP_SECTORS)) ? SECS_W'(MAX_MAP_SECTORS)
                                                             : req_secs;
    req_nbytes = CNT_W'(req_secs_clamped * SECTOR_BYTES);
  end

  // Read data of the map being worked on and its first clear bit.
  logic [7:0] rdata;
  logic [2:0] zpos;
  logic       byte_has_zero;
  always_comb begin
    rdata = sel_q ? sec_rdata_q : ino_rdata_q;
    zpos  = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (!rdata[k]) zpos = 3'(k);
    end
    byte_has_zero = (rdata != BYTE_FULL);
  end

  logic [BIT_W-1:0]  b_found;
  logic [IDX_W-1:0]  end_sum;
  logic [IDX_W-1:0]  limit;
  logic              too_long;
  logic [IDX_W-1:0]  idx_found, idx_run;
  always_comb begin
    b_found   = {pa_q, zpos};
    end_sum   = IDX_W'(b_found) + IDX_W'(run_q);
    limit     = IDX_W'({nbytes_q, 3'b000});
    too_long  = end_sum > limit;
    idx_found = IDX_W'(b_found) - IDX_W'(1) + IDX_W'(first_data_q);
    idx_run   = IDX_W'(b_q) - IDX_W'(1) + IDX_W'(first_data_q);
  end

  // Bits of the byte arriving at pa_q that lie inside the run [b_q, e_q].
  logic [2:0] lo, hi;
  logic [7:0] run_mask;
  always_comb begin
    lo = (pa_q == b_q[BIT_W-1:3]) ? b_q[2:0] : 3'd0;
    hi = (pa_q == e_q[BIT_W-1:3]) ? e_q[2:0] : 3'd7;
    run_mask = (BYTE_FULL << lo) & (BYTE_FULL >> (3'd7 - hi));
  end

  logic run_issue, scan_issue;
  assign scan_issue = (ia_q != nbytes_q);
  assign run_issue  = (ia_q <= CNT_W'(e_q[BIT_W-1:3]));

  // Memory write port, shared by loads, the inode bit set and the run fill.
  logic              we_ino, we_sec;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  always_comb begin
    we_ino  = 1'b0;
    we_sec  = 1'b0;
    wr_addr = pa_q;
    wr_data = rdata | run_mask;
    case (state_q)
      S_IDLE: begin
        if (in_fire && (in_func == FUNC_LOAD)) begin
          wr_addr = in_addr;
          wr_data = in_val;
          we_ino  = !in_sel;
          we_sec  = in_sel;
        end
      end
      S_SCAN: begin
        if (pv_q && byte_has_zero && !sel_q) begin
          wr_data = rdata | (8'd1 << zpos);
          we_ino  = 1'b1;
        end
      end
      S_FILL: begin
        we_sec = pv_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_ino) ino_mem_q[wr_addr] <= wr_data;
    if (we_sec) sec_mem_q[wr_addr] <= wr_data;
    ino_rdata_q <= ino_mem_q[ia_q[ADDR_W-1:0]];
    sec_rdata_q <= sec_mem_q[ia_q[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ino_secs_q   <= SECS_W'(1);
      sec_secs_q   <= SECS_W'(8);
      first_data_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_INODE_SECS:  ino_secs_q   <= cfg_data_i[SECS_W-1:0];
        REG_SECTOR_SECS: sec_secs_q   <= cfg_data_i[SECS_W-1:0];
        REG_FIRST_DATA:  first_data_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
      m_idx_q   <= '0;
      m_stat_q  <= STAT_OK;
      sel_q     <= 1'b0;
      nbytes_q  <= '0;
      ia_q      <= '0;
      pv_q      <= 1'b0;
      pa_q      <= '0;
      b_q       <= '0;
      e_q       <= '0;
      run_q     <= '0;
    end else begin
      if (m_axis_tready) m_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            ia_q     <= '0;
            pv_q     <= 1'b0;
            sel_q    <= (in_func == FUNC_SECTOR);
            nbytes_q <= req_nbytes;
            run_q    <= in_run;
            if ((in_func == FUNC_INODE) || (in_func == FUNC_SECTOR)) begin
              if (req_nbytes == '0) begin
                m_valid_q <= 1'b1;
                m_idx_q   <= '0;
                m_stat_q  <= STAT_FULL;
              end else begin
                state_q <= S_SCAN;
              end
            end else begin
              m_valid_q <= 1'b1;
              m_idx_q   <= '0;
              m_stat_q  <= STAT_OK;
            end
          end
        end
        S_SCAN: begin
          pv_q <= scan_issue;
          pa_q <= ia_q[ADDR_W-1:0];
          if (scan_issue) ia_q <= ia_q + CNT_W'(1);
          if (pv_q && byte_has_zero) begin
            pv_q <= 1'b0;
            if (!sel_q) begin
              state_q   <= S_IDLE;
              m_valid_q <= 1'b1;
              m_idx_q   <= IDX_W'(b_found);
              m_stat_q  <= STAT_OK;
            end else if (too_long) begin
              state_q   <= S_IDLE;
              m_valid_q <= 1'b1;
              m_idx_q   <= '0;
              m_stat_q  <= STAT_FULL;
            end else if (run_q == '0) begin
              state_q   <= S_IDLE;
              m_valid_q <= 1'b1;
              m_idx_q   <= idx_found;
              m_stat_q  <= STAT_OK;
            end else begin
              state_q <= S_CHECK;
              b_q     <= b_found;
              e_q     <= BIT_W'(end_sum - IDX_W'(1));
              ia_q    <= CNT_W'(pa_q);
            end
          end else if (!pv_q && !scan_issue) begin
            state_q   <= S_IDLE;
            m_valid_q <= 1'b1;
            m_idx_q   <= '0;
            m_stat_q  <= STAT_FULL;
          end
        end
        S_CHECK: begin
          pv_q <= run_issue;
          pa_q <= ia_q[ADDR_W-1:0];
          if (run_issue) ia_q <= ia_q + CNT_W'(1);
          if (pv_q && ((rdata & run_mask) != 8'd0)) begin
            // Claim nothing when any bit of the run is already taken.
            state_q   <= S_IDLE;
            pv_q      <= 1'b0;
            m_valid_q <= 1'b1;
            m_idx_q   <= '0;
            m_stat_q  <= STAT_CONFLICT;
          end else if (!pv_q && !run_issue) begin
            state_q <= S_FILL;
            ia_q    <= CNT_W'(b_q[BIT_W-1:3]);
          end
        end
        S_FILL: begin
          pv_q <= run_issue;
          pa_q <= ia_q[ADDR_W-1:0];
          if (run_issue) ia_q <= ia_q + CNT_W'(1);
          if (!pv_q && !run_issue) begin
            state_q   <= S_IDLE;
            m_valid_q <= 1'b1;
            m_idx_q   <= idx_run;
            m_stat_q  <= STAT_OK;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/bisa_checker.sv
// Port-level checker for the allocator core, attached by the bind below.
// Depends on bisa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bisa_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [bisa_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input logic [bisa_pkg::OUT_USER_W-1:0]    m_axis_tuser
);
  import bisa_pkg::*;

  // A stalled result keeps its contents.
  `BISA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // A failed allocation reports index zero.
  `BISA_ASSERT_NOW(a_fail_zero, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser != STAT_OK), m_axis_tdata == '0)

  // Every reported status is one of the defined ones.
  `BISA_ASSERT_NOW(a_stat_legal, clk_i, rst_ni, m_axis_tvalid,
    m_axis_tuser == STAT_OK || m_axis_tuser == STAT_FULL || m_axis_tuser == STAT_CONFLICT)

  // No request is taken while the previous result is stuck at the output.
  `BISA_ASSERT_NOW(a_no_take_on_stall, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready, !s_axis_tready)

endmodule

bind bitmap_inode_sector_allocator_core bisa_checker u_bisa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
